// File: hw/rtl/spm_pkg.sv
// Shared types and constants for the sparse polynomial multiplier.
// Used by spm_term_store, spm_cell and sparse_polynomial_multiplier; no dependencies.
package spm_pkg;

  localparam int unsigned MaxTermsDefault = 8;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned ExpW      = 8;
  localparam int unsigned ProdCoefW = 2 * CoefW;
  localparam int unsigned SumExpW   = ExpW + 1;
  localparam int unsigned AccW      = 38;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_MULTIPLY    = 2'd2
  } spm_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT
  } spm_state_e;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [CoefW-1:0] coefficient;
    logic [ExpW-1:0]        exponent;
  } spm_in_t;

  typedef struct packed {
    logic signed [AccW-1:0] product_coefficient;
    logic [SumExpW-1:0]     product_exponent;
    logic                   term_valid;
    logic                   dropped;
    logic                   last;
  } spm_out_t;

  // Product travelling along the cell row
  typedef struct packed {
    logic                        valid;
    logic [SumExpW-1:0]          exp;
    logic signed [ProdCoefW-1:0] coef;
  } spm_prod_t;

  // Result term held by one cell
  typedef struct packed {
    logic                   occ;
    logic [SumExpW-1:0]     exp;
    logic signed [AccW-1:0] coef;
  } spm_entry_t;

endpackage

// File: hw/rtl/spm_term_store.sv
// Term store for one input polynomial: coefficient/exponent registers and a fill count.
// Depends on spm_pkg.
module spm_term_store #(
  parameter int unsigned MaxTerms = spm_pkg::MaxTermsDefault,
  parameter int unsigned IdxW     = (MaxTerms > 1) ? $clog2(MaxTerms) : 1,
  parameter int unsigned CntW     = $clog2(MaxTerms + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic signed [spm_pkg::CoefW-1:0] coef_i,
  input  logic [spm_pkg::ExpW-1:0]         exp_i,
  input  logic                             clear_i,
  input  logic [IdxW-1:0]                  rd_idx_i,
  output logic signed [spm_pkg::CoefW-1:0] rd_coef_o,
  output logic [spm_pkg::ExpW-1:0]         rd_exp_o,
  output logic [CntW-1:0]                  count_o,
  output logic                             full_o
);
  import spm_pkg::*;

  logic signed [CoefW-1:0] coef_q [MaxTerms];
  logic [ExpW-1:0]         exp_q  [MaxTerms];
  logic [CntW-1:0]         count_q, count_d;
  logic                    wr_en;

  assign full_o  = (count_q == CntW'(MaxTerms));
  assign wr_en   = load_i && !full_o;
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      coef_q[count_q[IdxW-1:0]] <= coef_i;
      exp_q[count_q[IdxW-1:0]]  <= exp_i;
    end
  end

  assign rd_coef_o = coef_q[rd_idx_i];
  assign rd_exp_o  = exp_q[rd_idx_i];

endmodule

// File: hw/rtl/spm_cell.sv
// One cell of the result row: holds one result term, accumulates a matching product
// or claims itself when free, otherwise passes the product on. Depends on spm_pkg.
module spm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spm_pkg::spm_prod_t  prod_i,
  input  logic                shift_i,
  input  spm_pkg::spm_entry_t next_i,
  output spm_pkg::spm_prod_t  prod_o,
  output spm_pkg::spm_entry_t entry_o
);
  import spm_pkg::*;

  spm_entry_t ent_q, ent_d;
  spm_prod_t  pass_q, pass_d;

  always_comb begin
    ent_d  = ent_q;
    pass_d = '0;
    if (shift_i) begin
      // unload: take the right neighbor's term
      ent_d = next_i;
    end else if (prod_i.valid) begin
      if (ent_q.occ && (ent_q.exp == prod_i.exp)) begin
        ent_d.coef = ent_q.coef + AccW'(prod_i.coef);
      end else if (!ent_q.occ) begin
        ent_d.occ  = 1'b1;
        ent_d.exp  = prod_i.exp;
        ent_d.coef = AccW'(prod_i.coef);
      end else begin
        pass_d = prod_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q  <= '0;
      pass_q <= '0;
    end else begin
      ent_q  <= ent_d;
      pass_q <= pass_d;
    end
  end

  assign prod_o  = pass_q;
  assign entry_o = ent_q;

endmodule

// File: hw/rtl/sparse_polynomial_multiplier.sv
// Sparse polynomial multiplier. Loads (cmd 0 first, cmd 1 second polynomial) write one
// term each; a full store drops the term and sets the dropped flag. A multiply walks all
// n1*n2 term pairs through a single 16x16 multiplier, one pair per cycle, and feeds the
// products into a row of MAX_TERMS^2 result cells that merge equal exponents in order of
// first appearance. After the last pair the row drains, then shifts out one result
// term per cycle while the output does not stall; an empty product skips the pair
// walk and the drain and emits its one invalid term at once. No input is taken until
// the last result transaction completes. Depends on spm_pkg, spm_term_store, spm_cell.
module sparse_polynomial_multiplier #(
  parameter int unsigned MAX_TERMS = spm_pkg::MaxTermsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  spm_pkg::spm_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output spm_pkg::spm_out_t out_data_o
);
  import spm_pkg::*;

  localparam int unsigned NumCells = MAX_TERMS * MAX_TERMS;
  localparam int unsigned IdxW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CntW     = $clog2(MAX_TERMS + 1);
  localparam int unsigned DrainW   = $clog2(NumCells + 2);

  spm_state_e state_q, state_d;

  logic                    in_fire, out_fire, last_term, mul_empty, pair_last;
  logic                    load_first, load_second, clear_stores, shift_row;
  logic                    first_full, second_full;
  logic [CntW-1:0]         first_cnt, second_cnt;
  logic [IdxW-1:0]         i_q, i_d, j_q, j_d;
  logic [DrainW-1:0]       drain_q, drain_d;
  logic                    ovf_q, ovf_d;
  logic signed [CoefW-1:0] a_coef, b_coef;
  logic [ExpW-1:0]         a_exp, b_exp;
  spm_prod_t               mul_q, mul_d;
  spm_prod_t               flow [NumCells+1];
  spm_entry_t              ent  [NumCells+1];

  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_fire  = out_valid_o && !out_stall_i;
  assign last_term = !ent[1].occ;
  assign mul_empty = (first_cnt == '0) || (second_cnt == '0);
  assign pair_last = (CntW'(i_q) + CntW'(1) == first_cnt) &&
                     (CntW'(j_q) + CntW'(1) == second_cnt);

  assign load_first   = in_fire && (in_data_i.cmd == CMD_LOAD_FIRST);
  assign load_second  = in_fire && (in_data_i.cmd == CMD_LOAD_SECOND);
  assign clear_stores = out_fire && last_term;
  assign shift_row    = out_fire;

  spm_term_store #(.MaxTerms(MAX_TERMS), .IdxW(IdxW), .CntW(CntW)) u_first (
    .clk_i, .rst_ni,
    .load_i   (load_first),
    .coef_i   (in_data_i.coefficient),
    .exp_i    (in_data_i.exponent),
    .clear_i  (clear_stores),
    .rd_idx_i (i_q),
    .rd_coef_o(a_coef),
    .rd_exp_o (a_exp),
    .count_o  (first_cnt),
    .full_o   (first_full)
  );

  spm_term_store #(.MaxTerms(MAX_TERMS), .IdxW(IdxW), .CntW(CntW)) u_second (
    .clk_i, .rst_ni,
    .load_i   (load_second),
    .coef_i   (in_data_i.coefficient),
    .exp_i    (in_data_i.exponent),
    .clear_i  (clear_stores),
    .rd_idx_i (j_q),
    .rd_coef_o(b_coef),
    .rd_exp_o (b_exp),
    .count_o  (second_cnt),
    .full_o   (second_full)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_data_i.cmd == CMD_MULTIPLY)) begin
          state_d = mul_empty ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL: begin
        if (pair_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_q == '0) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire && last_term) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    drain_d = drain_q;
    ovf_d   = ovf_q;
    mul_d   = '0;
    if ((load_first && first_full) || (load_second && second_full)) begin
      ovf_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        i_d     = '0;
        j_d     = '0;
        drain_d = DrainW'(NumCells + 1);
      end
      ST_MUL: begin
        mul_d.valid = 1'b1;
        mul_d.coef  = a_coef * b_coef;
        mul_d.exp   = SumExpW'(a_exp) + SumExpW'(b_exp);
        // advance inner index, wrap into outer
        if (CntW'(j_q) + CntW'(1) == second_cnt) begin
          j_d = '0;
          i_d = i_q + IdxW'(1);
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q - DrainW'(1);
      end
      ST_EMIT: begin
        if (clear_stores) ovf_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      drain_q <= '0;
      ovf_q   <= 1'b0;
      mul_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
      mul_q   <= mul_d;
    end
  end

  assign flow[0]       = mul_q;
  assign ent[NumCells] = '0;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    spm_cell u_cell (
      .clk_i, .rst_ni,
      .prod_i (flow[k]),
      .shift_i(shift_row),
      .next_i (ent[k+1]),
      .prod_o (flow[k+1]),
      .entry_o(ent[k])
    );
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  always_comb begin
    out_data_o                     = '0;
    out_data_o.term_valid          = ent[0].occ;
    out_data_o.dropped             = ovf_q;
    out_data_o.last                = last_term;
    if (ent[0].occ) begin
      out_data_o.product_coefficient = ent[0].coef;
      out_data_o.product_exponent    = ent[0].exp;
    end
  end

endmodule

// File: tb/sv/sparse_polynomial_multiplier_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_polynomial_multiplier: predicts product terms per command
// and compares each output transaction in order. Depends on spm_pkg and the block's RTL only.
module sparse_polynomial_multiplier_tb;
  import spm_pkg::*;

  localparam int unsigned Terms       = MaxTermsDefault;
  localparam logic [1:0]  CmdUnused   = 2'd3;
  localparam int unsigned ItemTarget  = 210;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = 2 * Terms * Terms + 16;
  localparam int unsigned MaxReported = 10;

  typedef enum int {COEF_WIDE, COEF_EDGE, COEF_MIN} coef_mode_e;
  typedef enum int {EXP_WIDE, EXP_NARROW, EXP_SAME} exp_mode_e;

  // Keeps its own copy of both term stores and predicts the product terms
  class spm_scoreboard;
    logic signed [CoefW-1:0] coef_store [2][Terms];
    logic [ExpW-1:0]         pow_store  [2][Terms];
    int unsigned             fill [2] = '{0, 0};
    logic                    dropped_flag = 1'b0;
    spm_out_t                awaited_terms [$];
    int unsigned             mismatches = 0;

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MaxReported) $display("mismatch: %s", msg);
    endfunction

    function int unsigned pending();
      return awaited_terms.size();
    endfunction

    function void take_command(spm_in_t item);
      logic signed [AccW-1:0] sums [$];
      logic [SumExpW-1:0]     powers [$];
      logic signed [AccW-1:0] prod;
      logic [SumExpW-1:0]     pow;
      spm_out_t               term;
      int                     hit;
      int unsigned            side;
      if (item.cmd == CMD_LOAD_FIRST || item.cmd == CMD_LOAD_SECOND) begin
        side = item.cmd[0];
        if (fill[side] < Terms) begin
          coef_store[side][fill[side]] = item.coefficient;
          pow_store[side][fill[side]]  = item.exponent;
          fill[side]++;
        end else begin
          dropped_flag = 1'b1;
        end
      end else if (item.cmd == CMD_MULTIPLY) begin
        for (int i = 0; i < fill[0]; i++) begin
          for (int j = 0; j < fill[1]; j++) begin
            prod = coef_store[0][i] * coef_store[1][j];
            pow  = pow_store[0][i] + pow_store[1][j];
            hit  = -1;
            foreach (powers[k]) if (powers[k] == pow) hit = k;
            // append a new exponent in order of first appearance, zero sums stay
            if (hit < 0) begin
              sums.push_back(prod);
              powers.push_back(pow);
            end else begin
              sums[hit] += prod;
            end
          end
        end
        if (sums.size() == 0) begin
          term         = '0;
          term.dropped = dropped_flag;
          term.last    = 1'b1;
          awaited_terms.push_back(term);
        end else begin
          foreach (sums[k]) begin
            term.product_coefficient = sums[k];
            term.product_exponent    = powers[k];
            term.term_valid          = 1'b1;
            term.dropped             = dropped_flag;
            term.last                = (k == sums.size() - 1);
            awaited_terms.push_back(term);
          end
        end
        fill[0]      = 0;
        fill[1]      = 0;
        dropped_flag = 1'b0;
      end
    endfunction

    function void check_term(spm_out_t got);
      spm_out_t want;
      if (awaited_terms.size() == 0) begin
        flag($sformatf("unexpected term coef %0d exp %0d valid %0b dropped %0b last %0b",
                       got.product_coefficient, got.product_exponent, got.term_valid,
                       got.dropped, got.last));
        return;
      end
      want = awaited_terms.pop_front();
      if (got !== want) begin
        flag($sformatf({"expected coef %0d exp %0d valid %0b dropped %0b last %0b, ",
                        "got coef %0d exp %0d valid %0b dropped %0b last %0b"},
                       want.product_coefficient, want.product_exponent, want.term_valid,
                       want.dropped, want.last, got.product_coefficient,
                       got.product_exponent, got.term_valid, got.dropped, got.last));
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  spm_in_t       in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  spm_out_t      out_data_o;
  int unsigned   idle_pct  = 0;
  int unsigned   stall_pct = 0;
  spm_scoreboard sb = new();

  sparse_polynomial_multiplier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic spm_in_t make_item(logic [1:0] cmd, logic [15:0] coef, logic [7:0] power);
    spm_in_t t;
    t.cmd         = cmd;
    t.coefficient = coef;
    t.exponent    = power;
    return t;
  endfunction

  function automatic spm_in_t random_load(logic [1:0] cmd, coef_mode_e cm, exp_mode_e em,
                                          logic [7:0] base);
    logic [15:0] coef;
    logic [7:0]  power;
    case (cm)
      COEF_EDGE: begin
        case ($urandom_range(4))
          0:       coef = 16'h8000;
          1:       coef = 16'h7fff;
          2:       coef = 16'hffff;
          3:       coef = 16'h0000;
          default: coef = 16'h0001;
        endcase
      end
      COEF_MIN: coef = 16'h8000;
      default:  coef = 16'($urandom);
    endcase
    case (em)
      EXP_NARROW: power = base + 8'($urandom_range(3));
      EXP_SAME:   power = base;
      default:    power = 8'($urandom_range(255));
    endcase
    return make_item(cmd, coef, power);
  endfunction

  // mostly small stores; sometimes more than fit, so the extra loads are dropped
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(4);
    if (r < 92) return $urandom_range(8, 5);
    return $urandom_range(Terms + 2, Terms + 1);
  endfunction

  task automatic send_item(spm_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_command(item);
  endtask

  // result side: check accepted transactions, then pick the next stall
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_term(out_data_o);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    spm_in_t     seq [$];
    int unsigned sent;
    int unsigned n1;
    int unsigned n2;
    int unsigned shape;
    coef_mode_e  cm;
    exp_mode_e   em;
    logic [7:0]  base;
    sent        = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty product with both stores empty
    seq.push_back(make_item(CMD_MULTIPLY, 16'h0000, 8'h00));
    // largest single product at the top exponent, with an unused command in between
    seq.push_back(make_item(CMD_LOAD_FIRST, 16'h8000, 8'hff));
    seq.push_back(make_item(CmdUnused, 16'h7fff, 8'hff));
    seq.push_back(make_item(CMD_LOAD_SECOND, 16'h8000, 8'hff));
    seq.push_back(make_item(CMD_MULTIPLY, 16'hffff, 8'hff));
    // (1 + x)(x - 1): the x term sums to zero and must still come out
    seq.push_back(make_item(CMD_LOAD_FIRST, 16'h0001, 8'h00));
    seq.push_back(make_item(CMD_LOAD_FIRST, 16'h0001, 8'h01));
    seq.push_back(make_item(CMD_LOAD_SECOND, 16'h0001, 8'h01));
    seq.push_back(make_item(CMD_LOAD_SECOND, 16'hffff, 8'h00));
    seq.push_back(make_item(CMD_MULTIPLY, 16'h0000, 8'h00));
    // both stores full, one load dropped, 64 distinct exponents
    for (int i = 0; i <= Terms; i++)
      seq.push_back(make_item(CMD_LOAD_FIRST, 16'h7fff, (i < Terms) ? 8'(i) : 8'd200));
    for (int j = 0; j < Terms; j++)
      seq.push_back(make_item(CMD_LOAD_SECOND, 16'h8000, 8'(j * Terms)));
    seq.push_back(make_item(CMD_MULTIPLY, 16'h0000, 8'h00));
    foreach (seq[i]) send_item(seq[i]);

    while (sent < ItemTarget) begin
      case ((sent * 4) / ItemTarget)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 72; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 7;  stall_pct = 7;  end
      endcase
      seq.delete();
      shape = $urandom_range(99);
      base  = 8'($urandom_range(255));
      if (shape < 85) begin
        if (shape < 10) begin
          // every product lands on one exponent: coefficient sum at its extreme in COEF_MIN mode
          n1 = Terms;
          n2 = Terms;
          cm = $urandom_range(1) ? COEF_MIN : COEF_EDGE;
          em = EXP_SAME;
        end else begin
          n1 = pick_size();
          n2 = pick_size();
          cm = coef_mode_e'($urandom_range(2));
          em = exp_mode_e'($urandom_range(2));
        end
        while (n1 + n2 > 0) begin
          if (n2 == 0 || (n1 > 0 && $urandom_range(1))) begin
            seq.push_back(random_load(CMD_LOAD_FIRST, cm, em, base));
            n1--;
          end else begin
            seq.push_back(random_load(CMD_LOAD_SECOND, cm, em, base));
            n2--;
          end
          if ($urandom_range(19) == 0)
            seq.push_back(make_item(CmdUnused, 16'($urandom), 8'($urandom)));
        end
        seq.push_back(make_item(CMD_MULTIPLY, 16'($urandom), 8'($urandom)));
      end else begin
        repeat ($urandom_range(4, 1))
          seq.push_back(make_item(2'($urandom_range(3)), 16'($urandom), 8'($urandom)));
      end
      foreach (seq[i]) begin
        send_item(seq[i]);
        if (seq[i].cmd != CmdUnused) sent++;
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding terms, then hold a while to catch strays
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
